[hdl/mta_pkg.sv]
package mta_pkg;

   localparam int OP_W     = 2;
   localparam int INDEX_W  = 6;
   localparam int DATA_W   = 16;
   localparam int STATUS_W = 2;
   localparam int ACT_W    = 7;
   localparam int PROD_W   = 2 * DATA_W;
   localparam int Q_SHIFT  = 13;

   localparam logic [OP_W-1:0] OP_LOAD      = 2'd0;
   localparam logic [OP_W-1:0] OP_SET       = 2'd1;
   localparam logic [OP_W-1:0] OP_ADD       = 2'd2;
   localparam logic [OP_W-1:0] OP_RECOMPUTE = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_MODE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_ACT  = 2'd2;

   typedef logic signed [DATA_W-1:0] sample_type;

endpackage

[hdl/mta_if.sv]
interface mta_req_if;
   logic                         valid;
   logic                         ready;
   logic [mta_pkg::OP_W-1:0]     op;
   logic [mta_pkg::INDEX_W-1:0]  mode_index;
   logic [mta_pkg::INDEX_W-1:0]  actuator_index;
   mta_pkg::sample_type          value_in;
   logic                         emit;

   modport source(output valid, output op, output mode_index, output actuator_index,
                  output value_in, output emit, input ready);
   modport sink(input valid, input op, input mode_index, input actuator_index,
                input value_in, input emit, output ready);
endinterface

interface mta_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [mta_pkg::STATUS_W-1:0]  status;
   logic                          has_drive;
   logic [mta_pkg::ACT_W-1:0]     actuator;
   mta_pkg::sample_type           drive;
   logic                          last;

   modport source(output valid, output status, output has_drive, output actuator,
                  output drive, output last, input ready);
   modport sink(input valid, input status, input has_drive, input actuator,
                input drive, input last, output ready);
endinterface

interface mta_csr_if;
   logic                         valid;
   logic                         ready;
   logic [mta_pkg::INDEX_W-1:0]  mode_count;

   modport source(output valid, output mode_count, input ready);
   modport sink(input valid, input mode_count, output ready);
endinterface

[hdl/mta_ram.sv]
module mta_ram #(
   parameter int WIDTH  = 16,
   parameter int DEPTH  = 32,
   parameter int ADDR_W = 5
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

[hdl/modal_to_actuator_projector.sv]
// Channel   Direction  Fields
// req_ch    in         op, mode_index, actuator_index, value_in, emit
// rsp_ch    out        status, has_drive, actuator, drive, last
// csr_ch    in         mode_count
//
// A word without emit, or a rejected word, gives one registered status word; an accepted
// add first passes through S_ADD, which writes the saturated sum, also before an emit walk.
// A word with emit walks S_ISSUE, S_DRAIN, S_FINISH per actuator (only S_FINISH when count
// is 0); the single multiply-accumulate unit reads one matrix word per cycle in S_ISSUE.
// Reset is synchronous; it clears all coefficients through per-mode valid bits.
// A stalled result holds the walk; no new word is taken until the last result leaves.
module modal_to_actuator_projector #(
   parameter int ACTUATORS = 40,
   parameter int MAX_MODES = 32
) (
   input logic       clock,
   input logic       reset,
   mta_req_if.sink   req_ch,
   mta_rsp_if.source rsp_ch,
   mta_csr_if.sink   csr_ch
);

   localparam int MW     = (MAX_MODES > 1) ? $clog2(MAX_MODES) : 1;
   localparam int AW     = (ACTUATORS > 1) ? $clog2(ACTUATORS) : 1;
   localparam int MAT_AW = AW + MW;
   localparam int MAT_D  = ACTUATORS * (2 ** MW);
   localparam int ACC_W  = mta_pkg::PROD_W + $clog2(MAX_MODES + 1) + 1;
   localparam int Q_W    = ACC_W - mta_pkg::Q_SHIFT;
   localparam int DW     = mta_pkg::DATA_W;
   localparam int IW     = mta_pkg::INDEX_W;

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_ADD    = 5'b00010,
      S_ISSUE  = 5'b00100,
      S_DRAIN  = 5'b01000,
      S_FINISH = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic [IW-1:0] mode_count_ff, mode_count_in;
   logic [MAX_MODES-1:0] cvld_ff, cvld_in;
   logic [MW-1:0] mode_ff, mode_in;
   mta_pkg::sample_type value_ff, value_in;
   logic emit_ff, emit_in;
   logic [MW-1:0] mode_cnt_ff, mode_cnt_in;
   logic [AW-1:0] act_cnt_ff, act_cnt_in;
   logic issue_vld_ff, issue_vld_in;
   logic issue_last_ff, issue_last_in;
   logic issue_cvld_ff, issue_cvld_in;
   logic prod_vld_ff, prod_vld_in;
   logic prod_last_ff, prod_last_in;
   logic signed [mta_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [mta_pkg::STATUS_W-1:0] status_ff, status_in;
   logic has_drive_ff, has_drive_in;
   logic [mta_pkg::ACT_W-1:0] actuator_ff, actuator_in;
   mta_pkg::sample_type drive_ff, drive_in;
   logic last_ff, last_in;

   logic c_wr_en;
   logic [MW-1:0] c_wr_addr;
   mta_pkg::sample_type c_wr_data;
   logic [MW-1:0] c_rd_addr;
   mta_pkg::sample_type c_rd_data;
   logic m_wr_en;
   logic [MAT_AW-1:0] m_wr_addr;
   logic [MAT_AW-1:0] m_rd_addr;
   mta_pkg::sample_type m_rd_data;

   logic [IW-1:0] count;
   logic mode_ok;
   logic act_ok;
   logic [mta_pkg::STATUS_W-1:0] req_status;
   logic [MW-1:0] req_mode;
   logic [AW-1:0] req_act;
   logic signed [DW:0] add_sum;
   mta_pkg::sample_type add_sat;
   mta_pkg::sample_type coef;
   logic signed [ACC_W-1:0] rounded;
   logic signed [Q_W-1:0] q_val;
   mta_pkg::sample_type drive_sat;
   logic out_free;
   logic mode_last;
   logic act_last;

   mta_ram #(.WIDTH(DW), .DEPTH(MAX_MODES), .ADDR_W(MW)) u_coef_ram (
      .clock   (clock),
      .wr_en   (c_wr_en),
      .wr_addr (c_wr_addr),
      .wr_data (c_wr_data),
      .rd_addr (c_rd_addr),
      .rd_data (c_rd_data)
   );

   mta_ram #(.WIDTH(DW), .DEPTH(MAT_D), .ADDR_W(MAT_AW)) u_matrix_ram (
      .clock   (clock),
      .wr_en   (m_wr_en),
      .wr_addr (m_wr_addr),
      .wr_data (req_ch.value_in),
      .rd_addr (m_rd_addr),
      .rd_data (m_rd_data)
   );

   assign req_ch.ready     = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign csr_ch.ready     = 1'b1;
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.status    = status_ff;
   assign rsp_ch.has_drive = has_drive_ff;
   assign rsp_ch.actuator  = actuator_ff;
   assign rsp_ch.drive     = drive_ff;
   assign rsp_ch.last      = last_ff;

   always_comb begin
      count = (mode_count_ff < IW'(MAX_MODES)) ? mode_count_ff : IW'(MAX_MODES);
      mode_ok = (req_ch.mode_index != '0) && (req_ch.mode_index <= count);
      act_ok = (req_ch.actuator_index != '0)
               && ({1'b0, req_ch.actuator_index} <= (IW + 1)'(ACTUATORS));
      if (req_ch.op == mta_pkg::OP_RECOMPUTE) begin
         req_status = mta_pkg::ST_OK;
      end else if (!mode_ok) begin
         req_status = mta_pkg::ST_BAD_MODE;
      end else if ((req_ch.op == mta_pkg::OP_LOAD) && !act_ok) begin
         req_status = mta_pkg::ST_BAD_ACT;
      end else begin
         req_status = mta_pkg::ST_OK;
      end
      req_mode = MW'(req_ch.mode_index - IW'(1));
      req_act  = AW'(req_ch.actuator_index - IW'(1));

      add_sum = (cvld_ff[mode_ff] ? {c_rd_data[DW-1], c_rd_data} : '0)
                + {value_ff[DW-1], value_ff};
      if (add_sum > (DW + 1)'(signed'(32767))) begin
         add_sat = 16'sh7FFF;
      end else if (add_sum < -(DW + 1)'(signed'(32768))) begin
         add_sat = 16'sh8000;
      end else begin
         add_sat = add_sum[DW-1:0];
      end

      coef = issue_cvld_ff ? c_rd_data : '0;
      rounded = acc_ff + ACC_W'(signed'(4096));
      q_val = Q_W'(rounded >>> mta_pkg::Q_SHIFT);
      if (q_val > Q_W'(signed'(32767))) begin
         drive_sat = 16'sh7FFF;
      end else if (q_val < -Q_W'(signed'(32768))) begin
         drive_sat = 16'sh8000;
      end else begin
         drive_sat = q_val[DW-1:0];
      end

      out_free  = !rsp_valid_ff || rsp_ch.ready;
      mode_last = (IW'(mode_cnt_ff) == (count - IW'(1)));
      act_last  = (act_cnt_ff == AW'(ACTUATORS - 1));

      state_in      = state_ff;
      mode_count_in = csr_ch.valid ? csr_ch.mode_count : mode_count_ff;
      cvld_in       = cvld_ff;
      mode_in       = mode_ff;
      value_in      = value_ff;
      emit_in       = emit_ff;
      mode_cnt_in   = mode_cnt_ff;
      act_cnt_in    = act_cnt_ff;
      issue_vld_in  = 1'b0;
      issue_last_in = mode_last;
      issue_cvld_in = cvld_ff[mode_cnt_ff];
      prod_vld_in   = issue_vld_ff;
      prod_last_in  = issue_last_ff;
      prod_in       = coef * m_rd_data;
      acc_in        = prod_vld_ff ? acc_ff + ACC_W'(prod_ff) : acc_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      status_in     = status_ff;
      has_drive_in  = has_drive_ff;
      actuator_in   = actuator_ff;
      drive_in      = drive_ff;
      last_in       = last_ff;
      c_wr_en       = 1'b0;
      c_wr_addr     = req_mode;
      c_wr_data     = req_ch.value_in;
      c_rd_addr     = mode_cnt_ff;
      m_wr_en       = 1'b0;
      m_wr_addr     = {req_act, req_mode};
      m_rd_addr     = {act_cnt_ff, mode_cnt_ff};

      unique case (state_ff)
         S_IDLE: begin
            c_rd_addr = req_mode;
            if (req_ch.valid && req_ch.ready) begin
               mode_in     = req_mode;
               value_in    = req_ch.value_in;
               emit_in     = req_ch.emit;
               mode_cnt_in = '0;
               act_cnt_in  = '0;
               acc_in      = '0;
               if ((req_status != mta_pkg::ST_OK) || (!req_ch.emit
                   && (req_ch.op != mta_pkg::OP_ADD))) begin
                  rsp_valid_in = 1'b1;
                  status_in    = req_status;
                  has_drive_in = 1'b0;
                  actuator_in  = '0;
                  drive_in     = '0;
                  last_in      = 1'b1;
               end
               if (req_status == mta_pkg::ST_OK) begin
                  unique case (req_ch.op)
                     mta_pkg::OP_LOAD: begin
                        m_wr_en = 1'b1;
                     end
                     mta_pkg::OP_SET: begin
                        c_wr_en = 1'b1;
                        cvld_in[req_mode] = 1'b1;
                     end
                     mta_pkg::OP_ADD: begin
                        state_in = S_ADD;
                     end
                     default: begin
                     end
                  endcase
                  if (req_ch.emit && (req_ch.op != mta_pkg::OP_ADD)) begin
                     state_in = (count == '0) ? S_FINISH : S_ISSUE;
                  end
               end
            end
         end
         S_ADD: begin
            c_wr_en          = 1'b1;
            c_wr_addr        = mode_ff;
            c_wr_data        = add_sat;
            cvld_in[mode_ff] = 1'b1;
            if (emit_ff) begin
               state_in = S_ISSUE;
            end else begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               status_in    = mta_pkg::ST_OK;
               has_drive_in = 1'b0;
               actuator_in  = '0;
               drive_in     = '0;
               last_in      = 1'b1;
            end
         end
         S_ISSUE: begin
            issue_vld_in = 1'b1;
            if (mode_last) begin
               mode_cnt_in = '0;
               state_in    = S_DRAIN;
            end else begin
               mode_cnt_in = mode_cnt_ff + MW'(1);
            end
         end
         S_DRAIN: begin
            if (prod_vld_ff && prod_last_ff) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               status_in    = mta_pkg::ST_OK;
               has_drive_in = 1'b1;
               actuator_in  = mta_pkg::ACT_W'(act_cnt_ff) + mta_pkg::ACT_W'(1);
               drive_in     = drive_sat;
               last_in      = act_last;
               acc_in       = '0;
               mode_cnt_in  = '0;
               if (act_last) begin
                  state_in = S_IDLE;
               end else begin
                  act_cnt_in = act_cnt_ff + AW'(1);
                  state_in   = (count == '0) ? S_FINISH : S_ISSUE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         mode_count_ff <= IW'(32);
         cvld_ff       <= '0;
         issue_vld_ff  <= 1'b0;
         prod_vld_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         mode_count_ff <= mode_count_in;
         cvld_ff       <= cvld_in;
         issue_vld_ff  <= issue_vld_in;
         prod_vld_ff   <= prod_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      value_ff      <= value_in;
      emit_ff       <= emit_in;
      mode_cnt_ff   <= mode_cnt_in;
      act_cnt_ff    <= act_cnt_in;
      issue_last_ff <= issue_last_in;
      issue_cvld_ff <= issue_cvld_in;
      prod_last_ff  <= prod_last_in;
      prod_ff       <= prod_in;
      acc_ff        <= acc_in;
      status_ff     <= status_in;
      has_drive_ff  <= has_drive_in;
      actuator_ff   <= actuator_in;
      drive_ff      <= drive_in;
      last_ff       <= last_in;
   end

endmodule

[hdl/mta_checker.sv]
module mta_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [mta_pkg::STATUS_W-1:0] rsp_status,
   input logic                         rsp_has_drive,
   input logic [mta_pkg::ACT_W-1:0]    rsp_actuator,
   input mta_pkg::sample_type          rsp_drive,
   input logic                         rsp_last
);

   // A result word that is not taken stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

   // A stalled result word keeps its drive value and actuator number.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_drive) && $stable(rsp_actuator))
      else $error("stalled result word changed");

   // Only one request word is in work at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous one still in work");

   // A status word carries no drive and always closes its request.
   a_status_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_drive |-> rsp_last && (rsp_actuator == '0) && (rsp_drive == '0))
      else $error("malformed status word");

   // A drive word is always a successful one and names a real actuator.
   a_drive_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_has_drive |-> (rsp_status == mta_pkg::ST_OK) && (rsp_actuator != '0))
      else $error("malformed drive word");

endmodule

bind modal_to_actuator_projector mta_checker u_mta_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_status    (rsp_ch.status),
   .rsp_has_drive (rsp_ch.has_drive),
   .rsp_actuator  (rsp_ch.actuator),
   .rsp_drive     (rsp_ch.drive),
   .rsp_last      (rsp_ch.last)
);
